### src/pwdq_pkg.sv
// Package: formats, float constants and element conversion functions.
package pwdq_pkg;

  localparam int unsigned WordBitsDef = 32;
  localparam int unsigned MaxResults  = 32;
  localparam int unsigned CntW        = 6;
  localparam int unsigned FmtW        = 3;

  typedef enum logic [FmtW-1:0] {
    FMT_OFFSET8  = 3'd0,
    FMT_NIBBLE4  = 3'd1,
    FMT_SIGNED2  = 3'd2,
    FMT_TERNARY2 = 3'd3,
    FMT_BINARY1  = 3'd4,
    FMT_HALF     = 3'd5,
    FMT_RAW      = 3'd6,
    FMT_RAW_ALT  = 3'd7
  } fmt_e;

  localparam logic [31:0] FpOne    = 32'h3F80_0000;
  localparam logic [31:0] FpNegOne = 32'hBF80_0000;
  localparam logic [31:0] FpNegTwo = 32'hC000_0000;
  localparam logic [31:0] FpQNan   = 32'h7FC0_0000;

  function automatic logic [4:0] elem_width_log2(input fmt_e f);
    logic [4:0] r;
    case (f)
      FMT_OFFSET8:               r = 5'd3;
      FMT_NIBBLE4:               r = 5'd2;
      FMT_SIGNED2, FMT_TERNARY2: r = 5'd1;
      FMT_BINARY1:               r = 5'd0;
      FMT_HALF:                  r = 5'd4;
      default:                   r = 5'd5;
    endcase
    return r;
  endfunction

  // Exact single for a small signed integer k over 2^s (|k| < 256).
  function automatic logic [31:0] int_to_single(input logic signed [8:0] k,
                                                input logic [2:0] s);
    logic [7:0] a;
    logic [2:0] p;
    logic [7:0] e;
    logic [31:0] r;
    a = k[8] ? 8'(-k) : k[7:0];
    p = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (a[j]) p = 3'(j);
    end
    e = 8'd127 + 8'(p) - 8'(s);
    if (a == 8'd0) r = 32'h0;
    else r = {k[8], e, 23'((24'(a) << (5'd23 - 5'(p))))};
    return r;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] e;
    logic [9:0] m;
    logic [3:0] p;
    logic [31:0] r;
    e = h[14:10];
    m = h[9:0];
    p = 4'd0;
    for (int j = 0; j < 10; j++) begin
      if (m[j]) p = 4'(j);
    end
    if (e == 5'd0) begin
      if (m == 10'd0) r = {h[15], 31'h0};
      else r = {h[15], 8'(8'(p) + 8'd103), 23'((23'(m) << (5'd23 - 5'(p))))};
    end else if (e == 5'h1F) begin
      r = (m == 10'd0) ? {h[15], 31'h7F80_0000} : FpQNan;
    end else begin
      r = {h[15], 8'(8'(e) + 8'd112), m, 13'h0};
    end
    return r;
  endfunction

endpackage

### src/pwdq_if.sv
// Valid/ready channel interface carrying a generic payload.
interface pwdq_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/pwdq_front.sv
// Front end: accept words, saturate count, push jobs into a two-entry queue.
module pwdq_front #(
  parameter int unsigned WordBits = pwdq_pkg::WordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwdq_pkg::fmt_e         fmt_i,
  input  logic [WordBits-1:0]    word_i,
  input  logic [pwdq_pkg::CntW-1:0] count_i,
  input  logic                   last_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   job_valid_o,
  input  logic                   job_pop_i,
  output logic [WordBits-1:0]    job_word_o,
  output logic [pwdq_pkg::CntW-1:0] job_count_o,
  output logic                   job_last_o,
  output pwdq_pkg::fmt_e         job_fmt_o
);
  import pwdq_pkg::*;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic [CntW-1:0]     count;
    logic                last;
    fmt_e                fmt;
  } job_t;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] fill_q;
  logic [4:0] lw;
  logic [6:0] cap;
  logic [CntW-1:0] n;
  logic       push, pop;

  always_comb begin
    lw  = elem_width_log2(fmt_i);
    cap = 7'((WordBits >> lw) > MaxResults ? MaxResults : (WordBits >> lw));
    n   = (7'(count_i) > cap) ? CntW'(cap) : count_i;
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && (n != '0);
  assign pop         = job_pop_i && (fill_q != 2'd0);
  assign job_valid_o = (fill_q != 2'd0);
  assign job_word_o  = mem_q[rp_q].word;
  assign job_count_o = mem_q[rp_q].count;
  assign job_last_o  = mem_q[rp_q].last;
  assign job_fmt_o   = mem_q[rp_q].fmt;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{word: word_i, count: n, last: last_i, fmt: fmt_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      fill_q <= fill_q + 2'(push) - 2'(pop);
    end
  end
endmodule

### src/pwdq_back.sv
// Back end: step through a job's elements, convert, drive a registered output.
module pwdq_back #(
  parameter int unsigned WordBits = pwdq_pkg::WordBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_pop_o,
  input  logic [WordBits-1:0]    job_word_i,
  input  logic [pwdq_pkg::CntW-1:0] job_count_i,
  input  logic                   job_last_i,
  input  pwdq_pkg::fmt_e         job_fmt_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [31:0]            value_o,
  output logic                   last_elem_o,
  output logic                   tensor_end_o
);
  import pwdq_pkg::*;

  localparam int unsigned ExtW = (WordBits > 32) ? WordBits : 32;

  logic [CntW-1:0] idx_q, idx_d;
  logic            oval_q;
  logic [31:0]     val_q, val_d;
  logic            le_q, te_q;
  logic            adv, fin;
  logic [ExtW-1:0] w, sh;
  logic [4:0]      lw;
  logic [CntW-1:0] bi;
  logic [31:0]     x;

  always_comb begin
    w  = ExtW'(job_word_i);
    lw = elem_width_log2(job_fmt_i);
    bi = (job_fmt_i == FMT_NIBBLE4) ? (idx_q ^ CntW'(1)) : idx_q;
    sh = w >> ((ExtW'(bi)) << lw);
    x  = sh[31:0];
    case (job_fmt_i)
      FMT_OFFSET8:  val_d = int_to_single(9'(x[7:0]) - 9'sd128, 3'd7);
      FMT_NIBBLE4:  val_d = int_to_single(9'(x[3:0]) - 9'sd8, 3'd3);
      FMT_SIGNED2: begin
        case (x[1:0])
          2'd0:    val_d = 32'h0;
          2'd1:    val_d = FpOne;
          2'd2:    val_d = FpNegTwo;
          default: val_d = FpNegOne;
        endcase
      end
      FMT_TERNARY2: val_d = (x[1:0] == 2'd0) ? FpNegOne : (x[1:0] == 2'd1) ? 32'h0 : FpOne;
      FMT_BINARY1:  val_d = x[0] ? FpOne : FpNegOne;
      FMT_HALF:     val_d = half_to_single(x[15:0]);
      default:      val_d = x;
    endcase
    adv   = job_valid_i && (!oval_q || out_ready_i);
    fin   = (idx_q + CntW'(1) == job_count_i);
    idx_d = adv ? (fin ? '0 : idx_q + CntW'(1)) : idx_q;
  end

  assign job_pop_o    = adv && fin;
  assign out_valid_o  = oval_q;
  assign value_o      = val_q;
  assign last_elem_o  = le_q;
  assign tensor_end_o = te_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      val_q <= val_d;
      le_q  <= fin;
      te_q  <= fin && job_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (adv) oval_q <= 1'b1;
      else if (out_ready_i) oval_q <= 1'b0;
    end
  end
endmodule

### src/packed_weight_dequantizer.sv
// Top level: packed weight dequantizer to single-precision values.
//  channel | dir | payload
//  in_ch   | in  | packed_word, valid_elements, last_word
//  out_ch  | out | value_bits, last_element, tensor_end
//  cfg_ch  | in  | format (3 bits)
// One element leaves per cycle while out_ch is ready; n = saturated count.
// A word gives n elements; a word with zero count is taken and gives nothing.
// Two-entry job queue sits between front and back; output is one register.
// Reset clears queue pointers, element index, output valid and format to offset8.
module packed_weight_dequantizer #(
  parameter int unsigned WordBits = pwdq_pkg::WordBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  pwdq_if.sink   in_ch,
  pwdq_if.source out_ch,
  pwdq_if.sink   cfg_ch
);
  import pwdq_pkg::*;

  fmt_e            fmt_q;
  logic            jv, jpop, jlast;
  logic [WordBits-1:0] jword;
  logic [CntW-1:0] jcnt;
  fmt_e            jfmt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fmt_q <= FMT_OFFSET8;
    else if (cfg_ch.valid) fmt_q <= fmt_e'(cfg_ch.data.format);
  end

  pwdq_front #(.WordBits(WordBits)) u_front (
    .clk_i, .rst_ni, .fmt_i(fmt_q),
    .word_i(in_ch.data.packed_word), .count_i(in_ch.data.valid_elements),
    .last_i(in_ch.data.last_word), .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .job_valid_o(jv), .job_pop_i(jpop), .job_word_o(jword), .job_count_o(jcnt),
    .job_last_o(jlast), .job_fmt_o(jfmt)
  );

  pwdq_back #(.WordBits(WordBits)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_pop_o(jpop), .job_word_i(jword),
    .job_count_i(jcnt), .job_last_i(jlast), .job_fmt_i(jfmt),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .value_o(out_ch.data.value_bits), .last_elem_o(out_ch.data.last_element),
    .tensor_end_o(out_ch.data.tensor_end)
  );

  a_te_implies_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.tensor_end |-> out_ch.data.last_element)
    else $error("tensor_end without last_element");
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jpop |-> jv) else $error("job pop from empty queue");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data.value_bits))
    else $error("stalled result changed");
endmodule

### dv/pwdq_tb_pkg.sv
// Payload types of the dequantizer's channels, and per-format element capacity.
`timescale 1ns / 100ps
package pwdq_tb_pkg;
  import pwdq_pkg::*;

  typedef struct packed {
    logic [31:0] packed_word;
    logic [5:0]  valid_elements;
    logic        last_word;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last_element;
    logic        tensor_end;
  } out_word_t;

  typedef struct packed {
    fmt_e format;
  } cfg_word_t;

  function automatic int unsigned fmt_capacity(input fmt_e f);
    case (f)
      FMT_OFFSET8:               return 4;
      FMT_NIBBLE4:               return 8;
      FMT_SIGNED2, FMT_TERNARY2: return 16;
      FMT_BINARY1:               return 32;
      FMT_HALF:                  return 2;
      default:                   return 1;
    endcase
  endfunction
endpackage

### dv/pwdq_checker.sv
// Checker: predicts every dequantized element and compares it with the output.
`timescale 1ns / 100ps
module pwdq_checker
  import pwdq_pkg::*;
  import pwdq_tb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_word_t cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  fmt_e      fmt_q;
  out_word_t elem_queue[$];

  function automatic logic [31:0] scaled_int(input int k, input int s);
    int a;
    int p;
    logic [31:0] mag;
    if (k == 0) return 32'h0;
    a = (k < 0) ? -k : k;
    p = 0;
    for (int j = 0; j < 9; j++) if ((a >> j) & 1) p = j;
    mag = 32'(a) << (23 - p);
    return {(k < 0), 8'(127 + p - s), mag[22:0]};
  endfunction

  function automatic logic [31:0] half_bits(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  mt;
    logic [31:0] sh;
    int          p;
    ex = h[14:10];
    mt = h[9:0];
    if (ex == 5'd0) begin
      if (mt == 10'd0) return {h[15], 31'h0};
      p = 0;
      for (int j = 0; j < 10; j++) if (mt[j]) p = j;
      sh = 32'(mt) << (23 - p);
      return {h[15], 8'(p + 103), sh[22:0]};
    end
    if (ex == 5'h1F) return (mt == 10'd0) ? {h[15], 31'h7F80_0000} : 32'h7FC0_0000;
    return {h[15], 8'(32'(ex) + 112), mt, 13'h0};
  endfunction

  function automatic logic [31:0] elem_value(input fmt_e f, input logic [31:0] w,
                                             input int i);
    logic [31:0] x;
    case (f)
      FMT_OFFSET8: begin
        x = (w >> (i * 8)) & 32'hFF;
        return scaled_int(int'(x) - 128, 7);
      end
      FMT_NIBBLE4: begin
        x = (w >> ((i ^ 1) * 4)) & 32'hF;
        return scaled_int(int'(x) - 8, 3);
      end
      FMT_SIGNED2: begin
        x = (w >> (i * 2)) & 32'h3;
        return scaled_int(int'(x) - (x >= 2 ? 4 : 0), 0);
      end
      FMT_TERNARY2: begin
        x = (w >> (i * 2)) & 32'h3;
        return (x == 0) ? 32'hBF80_0000 : (x == 1) ? 32'h0 : 32'h3F80_0000;
      end
      FMT_BINARY1: return w[i] ? 32'h3F80_0000 : 32'hBF80_0000;
      FMT_HALF: return half_bits(w[i*16 +: 16]);
      default: return w;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    out_word_t   exp_w;
    if (!rst_ni) begin
      fmt_q        <= FMT_OFFSET8;
      fail_count_o <= 0;
      elem_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) fmt_q <= cfg_data_i.format;
      if (out_valid_i && out_ready_i) begin
        if (elem_queue.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected element %h", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = elem_queue.pop_front();
          if (exp_w !== out_data_i) begin
            if (fail_count_o < 10)
              $display("mismatch: value %h/%h last %b/%b end %b/%b (exp/act)",
                       exp_w.value_bits, out_data_i.value_bits,
                       exp_w.last_element, out_data_i.last_element,
                       exp_w.tensor_end, out_data_i.tensor_end);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        n = in_data_i.valid_elements;
        if (n > fmt_capacity(fmt_q)) n = fmt_capacity(fmt_q);
        for (int i = 0; i < n; i++) begin
          exp_w.value_bits   = elem_value(fmt_q, in_data_i.packed_word, i);
          exp_w.last_element = (i + 1 == n);
          exp_w.tensor_end   = (i + 1 == n) && in_data_i.last_word;
          elem_queue.push_back(exp_w);
        end
      end
    end
    pending_o = elem_queue.size();
  end

endmodule

### dv/tb_packed_weight_dequantizer.sv
// Testbench top: drives packed words and formats and reports the verdict.
`timescale 1ns / 100ps
module tb_packed_weight_dequantizer;
  import pwdq_pkg::*;
  import pwdq_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_cnt;
  logic calm;
  logic in_gaps;
  logic hold_go;
  logic hold_done;
  fmt_e cur_fmt;

  pwdq_if #(.payload_t(in_word_t))  in_ch ();
  pwdq_if #(.payload_t(out_word_t)) out_ch ();
  pwdq_if #(.payload_t(cfg_word_t)) cfg_ch ();

  packed_weight_dequantizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pwdq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt > 400000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic drain_wait();
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_format(input fmt_e f);
    drain_wait();
    cfg_ch.data  <= '{format: f};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_fmt = f;
  endtask

  task automatic send_word(input logic [31:0] w, input int cnt, input logic last);
    int n;
    if (in_gaps && !calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.data  <= '{packed_word: w, valid_elements: 6'(cnt), last_word: last};
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    fmt_e rand_fmts[8];
    int   cnt;
    rand_fmts = '{FMT_BINARY1, FMT_OFFSET8, FMT_HALF, FMT_NIBBLE4,
                  FMT_RAW_ALT, FMT_SIGNED2, FMT_TERNARY2, FMT_RAW};
    calm    = 1'b0;
    in_gaps = 1'b1;
    hold_go = 1'b0;
    cur_fmt = FMT_OFFSET8;
    rst_ni  <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '{format: FMT_OFFSET8};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_word(32'h007F_80FF, 4, 1'b1);
    send_word(32'hFFFF_FFFF, 63, 1'b0);
    send_word(32'h1234_5678, 0, 1'b1);
    idle_input();
    set_format(FMT_NIBBLE4);
    send_word(32'h0123_89EF, 8, 1'b1);
    send_word(32'h0000_0001, 3, 1'b0);
    idle_input();
    set_format(FMT_SIGNED2);
    send_word(32'hE4E4_E4E4, 16, 1'b1);
    idle_input();
    set_format(FMT_TERNARY2);
    send_word(32'hE4E4_E4E4, 40, 1'b0);
    idle_input();
    set_format(FMT_BINARY1);
    send_word(32'hA5A5_0F0F, 32, 1'b1);
    send_word(32'h0000_0000, 5, 1'b0);
    idle_input();
    set_format(FMT_HALF);
    send_word(32'h8000_0000, 2, 1'b0);
    send_word(32'h0001_03FF, 2, 1'b0);
    send_word(32'hFC00_7C00, 2, 1'b1);
    send_word(32'h7E01_0400, 1, 1'b0);
    send_word(32'h3C00_7BFF, 2, 1'b1);
    idle_input();
    set_format(FMT_RAW);
    send_word(32'h7FC1_2345, 1, 1'b1);
    send_word(32'hFFFF_FFFF, 0, 1'b0);
    idle_input();
    set_format(FMT_RAW_ALT);
    send_word(32'h1234_5678, 9, 1'b1);
    idle_input();

    for (int ph = 0; ph < 8; ph++) begin
      set_format(rand_fmts[ph]);
      if (ph == 7) calm = 1'b1;
      for (int k = 0; k < 32; k++) begin
        if (ph == 2 && k == 4) hold_go = 1'b1;
        if (ph == 4 && k == 16) begin
          idle_input();
          do @(negedge clk_i); while (pending != 0);
          @(posedge clk_i);
        end
        if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, 63);
        else cnt = $urandom_range(1, fmt_capacity(cur_fmt));
        send_word($urandom, cnt, 1'($urandom_range(0, 1)));
      end
      idle_input();
    end

    drain_wait();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
